### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property, disabled while reset is asserted.
`define CHK_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A stalled transfer keeps the given signal unchanged on the next edge.
`define CHK_HOLD(label, clk, rstn, vld, rdy, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) \
        ((vld) && !(rdy)) |=> $stable(sig)) else $error(msg);

`endif

### design/lmfe_pkg.sv
// Types, codes and helper functions of the LIN master frame engine.
`default_nettype none

package lmfe_pkg;

    localparam logic [3:0] MAX_DATA  = 4'd8;
    localparam logic [7:0] SYNC_BYTE = 8'h55;

    typedef enum logic [1:0] {
        KIND_TX_START = 2'd0,
        KIND_RX_START = 2'd1,
        KIND_BYTE     = 2'd2
    } in_kind_t;

    typedef enum logic [1:0] {
        OUT_BREAK  = 2'd0,
        OUT_BYTE   = 2'd1,
        OUT_RX_OK  = 2'd2,
        OUT_RX_ERR = 2'd3
    } out_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TX   = 2'd1,
        MODE_RX   = 2'd2
    } mode_t;

    typedef struct packed {
        out_kind_t  kind;
        logic [7:0] data;
        logic [3:0] fbytes;
        logic       last;
    } res_t;

    // Frame id with P0 in bit 6 and inverted P1 in bit 7.
    function automatic logic [7:0] protect_id(input logic [5:0] id);
        logic p0;
        logic p1;
        begin
            p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
            p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
            return {p1, p0, id};
        end
    endfunction

    // End-around carry add: the carry out folds back into bit 0.
    function automatic logic [7:0] add_carry(input logic [7:0] sum, input logic [7:0] b);
        logic [8:0] s;
        begin
            s = {1'b0, sum} + {1'b0, b};
            return s[7:0] + {7'd0, s[8]};
        end
    endfunction

endpackage

`default_nettype wire

### design/lin_master_frame_engine.sv
// LIN master frame engine: frame header, data echo and enhanced checksum.
//
// Input channel (s_*): start-transmit, start-receive and byte items.
// Result channel (m_*): break markers, bytes to send and receive status.
// A start item yields three transfers (break, sync 0x55, protected id);
// a transmit byte yields one, or two on the last byte (data, checksum);
// a receive data byte yields none and the checksum byte one status.
// m_last marks the final result of each input item.
// The first result is registered and is valid in the cycle after the input transfer.
// Throughput: one input item per cycle for items with at most one result,
// while m_ready stays high; an item with more results occupies the
// three-entry result buffer until the single output port has taken them.
// s_ready is high while the buffer is empty or its last entry is being
// taken in the same cycle.
// Reset (aresetn low, synchronous) empties the buffer and returns to idle.
// When the receiver stalls, the buffer holds and s_ready drops.
`default_nettype none

module lin_master_frame_engine import lmfe_pkg::*; (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire  [1:0] s_kind,
    input  wire  [5:0] s_frame_id,
    input  wire  [3:0] s_data_count,
    input  wire  [7:0] s_data_byte,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [1:0] m_out_kind,
    output logic [7:0] m_out_byte,
    output logic [3:0] m_frame_bytes,
    output logic       m_last
);

    mode_t      mode_reg, mode_next;
    logic [7:0] sum_reg, sum_next;
    logic [3:0] seen_reg, seen_next;
    logic [3:0] exp_reg, exp_next;
    logic [1:0] cnt_reg, cnt_next;
    res_t       slot_reg  [3];
    res_t       slot_next [3];

    res_t       new_slot [3];
    logic [1:0] new_cnt;
    logic       push;
    logic       pop;
    logic [7:0] pid;
    logic [7:0] sum_add;
    logic [3:0] seen_inc;
    logic [3:0] cnt_clamped;

    assign m_valid       = (cnt_reg != 2'd0);
    assign s_ready       = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign push          = s_valid && s_ready;
    assign pop           = m_valid && m_ready;
    assign m_out_kind    = slot_reg[0].kind;
    assign m_out_byte    = slot_reg[0].data;
    assign m_frame_bytes = slot_reg[0].fbytes;
    assign m_last        = slot_reg[0].last;

    assign pid      = protect_id(s_frame_id);
    assign sum_add  = add_carry(sum_reg, s_data_byte);
    assign seen_inc = seen_reg + 4'd1;

    always_comb begin
        if (s_data_count == 4'd0) begin
            cnt_clamped = 4'd1;
        end else if (s_data_count > MAX_DATA) begin
            cnt_clamped = MAX_DATA;
        end else begin
            cnt_clamped = s_data_count;
        end
    end

    // Frame state and the results of the offered item.
    always_comb begin
        mode_next = mode_reg;
        sum_next  = sum_reg;
        seen_next = seen_reg;
        exp_next  = exp_reg;
        new_cnt   = 2'd0;
        for (int i = 0; i < 3; i++) begin
            new_slot[i] = '{kind: OUT_BREAK, data: 8'd0, fbytes: 4'd0, last: 1'b0};
        end
        case (s_kind)
            KIND_TX_START, KIND_RX_START: begin
                mode_next = (s_kind == KIND_TX_START) ? MODE_TX : MODE_RX;
                sum_next  = pid;
                seen_next = 4'd0;
                exp_next  = cnt_clamped;
                new_cnt   = 2'd3;
                new_slot[1] = '{kind: OUT_BYTE, data: SYNC_BYTE, fbytes: 4'd0, last: 1'b0};
                new_slot[2] = '{kind: OUT_BYTE, data: pid, fbytes: 4'd0, last: 1'b1};
            end
            KIND_BYTE: begin
                case (mode_reg)
                    MODE_TX: begin
                        sum_next  = sum_add;
                        seen_next = seen_inc;
                        new_slot[0] = '{kind: OUT_BYTE, data: s_data_byte,
                                        fbytes: 4'd0, last: 1'b1};
                        new_cnt = 2'd1;
                        if (seen_inc >= exp_reg) begin
                            new_slot[0].last = 1'b0;
                            new_slot[1] = '{kind: OUT_BYTE, data: ~sum_add,
                                            fbytes: 4'd0, last: 1'b1};
                            new_cnt   = 2'd2;
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_RX: begin
                        if (seen_reg < exp_reg) begin
                            sum_next  = sum_add;
                            seen_next = seen_inc;
                        end else begin
                            new_slot[0] = '{kind: (s_data_byte == ~sum_reg) ?
                                                  OUT_RX_OK : OUT_RX_ERR,
                                            data: 8'd0, fbytes: exp_reg + 4'd1,
                                            last: 1'b1};
                            new_cnt   = 2'd1;
                            mode_next = MODE_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Result buffer: load on an input transfer, shift down on an output one.
    always_comb begin
        cnt_next     = cnt_reg;
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        slot_next[2] = slot_reg[2];
        if (push) begin
            cnt_next = new_cnt;
            for (int i = 0; i < 3; i++) begin
                slot_next[i] = new_slot[i];
            end
        end else if (pop) begin
            cnt_next     = cnt_reg - 2'd1;
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            sum_reg  <= 8'd0;
            seen_reg <= 4'd0;
            exp_reg  <= 4'd0;
            cnt_reg  <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                mode_reg <= mode_next;
                sum_reg  <= sum_next;
                seen_reg <= seen_next;
                exp_reg  <= exp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

endmodule

`default_nettype wire

### design/lmfe_checker.sv
// Port-level checker for the LIN master frame engine, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module lmfe_checker import lmfe_pkg::*; (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_valid,
    input wire       s_ready,
    input wire       m_valid,
    input wire       m_ready,
    input wire [1:0] m_out_kind,
    input wire [7:0] m_out_byte,
    input wire [3:0] m_frame_bytes,
    input wire       m_last
);

    logic in_xfer;
    logic break_taken;
    logic sync_shown;
    logic is_status;
    logic status_ok;
    logic is_send;
    logic send_ok;

    assign in_xfer     = s_valid && s_ready;
    assign break_taken = m_valid && m_ready && (m_out_kind == OUT_BREAK);
    assign sync_shown  = m_valid && (m_out_kind == OUT_BYTE) && (m_out_byte == SYNC_BYTE)
                         && !m_last;
    assign is_status   = m_valid && (m_out_kind == OUT_RX_OK || m_out_kind == OUT_RX_ERR);
    assign status_ok   = m_last && (m_out_byte == 8'd0) && (m_frame_bytes >= 4'd2);
    assign is_send     = m_valid && (m_out_kind == OUT_BREAK || m_out_kind == OUT_BYTE);
    assign send_ok     = (m_frame_bytes == 4'd0)
                         && !(m_out_kind == OUT_BREAK && (m_last || m_out_byte != 8'd0));

    `CHK_HOLD(a_out_hold, aclk, aresetn, m_valid, m_ready, m_out_byte, "stalled result changed")

    // A break is always followed by the sync byte of the same header.
    `CHK_ASSERT(a_sync_after_break, aclk, aresetn, break_taken |=> sync_shown, "no sync after break")

    // Status results close the frame and carry no byte.
    `CHK_ASSERT(a_status_fields, aclk, aresetn, is_status |-> status_ok, "bad status fields")

    // Only status results report a byte count; a break is never final.
    `CHK_ASSERT(a_send_fields, aclk, aresetn, is_send |-> send_ok, "bad send fields")

    // With results pending, an input transfer only happens as the last one drains.
    `CHK_ASSERT(a_accept_drain, aclk, aresetn, (in_xfer && m_valid) |-> m_ready, "early accept")

endmodule

bind lin_master_frame_engine lmfe_checker u_lmfe_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_kind    (m_out_kind),
    .m_out_byte    (m_out_byte),
    .m_frame_bytes (m_frame_bytes),
    .m_last        (m_last)
);

`default_nettype wire
